>>> rtl/assert_macros.svh
// Assertion shorthands used by the calculator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/kfc_pkg.sv
package kfc_pkg;

  localparam logic [7:0] KEY_CLEAR  = 8'd13;
  localparam logic [7:0] KEY_PLUS   = 8'h2B;
  localparam logic [7:0] KEY_MINUS  = 8'h2D;
  localparam logic [7:0] KEY_TIMES  = 8'h2A;
  localparam logic [7:0] KEY_DIVIDE = 8'h25;
  localparam logic [7:0] KEY_EQUALS = 8'h3D;
  localparam logic [7:0] DIGIT_BASE = 8'd10;

  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = 3'd7;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_DIGIT = 2'd1,
    ECHO_CHAR  = 2'd2,
    ECHO_CLEAR = 2'd3
  } echo_t;

  typedef struct packed {
    logic       start;
    op_t        op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] result;
  } alu_rsp_t;

  function automatic op_t op_of(input logic [7:0] key);
    op_t op;
    case (key)
      KEY_PLUS:   op = OP_ADD;
      KEY_MINUS:  op = OP_SUB;
      KEY_TIMES:  op = OP_MUL;
      KEY_DIVIDE: op = OP_DIV;
      default:    op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

>>> rtl/kfc_key_if.sv
interface kfc_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

>>> rtl/kfc_res_if.sv
interface kfc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] echo_kind;
  logic [7:0] echo_value;
  logic       result_valid;
  logic [7:0] result_value;
  logic       is_locked;

  modport source (
    output valid, output echo_kind, output echo_value, output result_valid,
    output result_value, output is_locked, input ready
  );
  modport sink (
    input valid, input echo_kind, input echo_value, input result_valid,
    input result_value, input is_locked, output ready
  );
endinterface

>>> rtl/kfc_alu.sv
module kfc_alu (
  input  logic              clk,
  input  logic              rst,
  input  kfc_pkg::alu_req_t req,
  output kfc_pkg::alu_rsp_t rsp
);
  import kfc_pkg::*;

  logic              busy;
  logic              done;
  op_t               op;
  logic [STEP_W-1:0] step;
  logic [7:0]        result;
  logic [7:0]        acc;
  logic [7:0]        mcand;
  logic [7:0]        mplier;
  logic [7:0]        rem;
  logic [7:0]        quo;
  logic [7:0]        dvsr;

  logic       done_next;
  logic [7:0] acc_next;
  logic [8:0] shifted;
  logic       fits;
  logic [8:0] diff;
  logic [7:0] rem_next;
  logic [7:0] quo_next;

  always_comb begin
    acc_next = mplier[0] ? acc + mcand : acc;
    shifted  = {rem, quo[7]};
    fits     = shifted >= {1'b0, dvsr};
    diff     = shifted - {1'b0, dvsr};
    rem_next = fits ? diff[7:0] : shifted[7:0];
    quo_next = {quo[6:0], fits};
    if (req.start) begin
      done_next = !(req.op == OP_MUL || (req.op == OP_DIV && req.b != '0));
    end else begin
      done_next = busy && (step == LAST_STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= done_next;
      if (req.start) begin
        op   <= req.op;
        step <= '0;
        case (req.op)
          OP_ADD: begin
            result <= req.a + req.b;
          end
          OP_SUB: begin
            result <= req.a - req.b;
          end
          OP_MUL: begin
            acc    <= '0;
            mcand  <= req.b;
            mplier <= req.a;
            busy   <= 1'b1;
          end
          OP_DIV: begin
            if (req.b == '0) begin
              result <= '0;
            end else begin
              rem  <= '0;
              quo  <= req.a;
              dvsr <= req.b;
              busy <= 1'b1;
            end
          end
          default: begin
            result <= req.a;
          end
        endcase
      end else if (busy) begin
        step <= step + 1'b1;
        if (op == OP_MUL) begin
          acc    <= acc_next;
          mcand  <= {mcand[6:0], 1'b0};
          mplier <= {1'b0, mplier[7:1]};
        end else begin
          rem <= rem_next;
          quo <= quo_next;
        end
        if (step == LAST_STEP) begin
          busy   <= 1'b0;
          result <= (op == OP_MUL) ? acc_next : quo_next;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

>>> rtl/keypad_four_function_calculator.sv
// Keypad four-function calculator.
// key_chan carries one key code per word: digits 0 to 9, 13 for clear, and the
// ASCII characters + - * % = as operators. result_chan returns exactly one word
// per key with the echo, the result of an equals key and the lock flag.
// A key is taken only while the block is idle. Digits, clear, ignored keys and
// any key while locked go through the put state into the output register. An
// operator or equals key first applies the pending operation: directly when it
// is none, + or -, or a division by zero, and over the eight steps of the
// shared shift-add and restoring-divide unit for * or %. The block is ready
// again as the word enters the output register, so a key is taken only once
// the word of the last key has been put. The next key is taken even while the
// previous word still waits in the output register. If the receiver stalls, a
// finished word waits until the output register is free, and no key is taken
// meanwhile. After reset the operands are zero, no operator is pending, the
// first operand is being entered, and the block is unlocked and idle with an
// empty output register.
module keypad_four_function_calculator (
  input logic  clk,
  input logic  rst,
  kfc_key_if.sink   key_chan,
  kfc_res_if.source result_chan
);
  import kfc_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_PUT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [7:0] key;
  logic [7:0] first_operand;
  logic [7:0] second_operand;
  op_t        pending_op;
  logic       entering_first;
  logic       entering_second;
  logic       locked;

  logic [7:0] first_operand_next;
  logic [7:0] second_operand_next;
  op_t        pending_op_next;
  logic       entering_first_next;
  logic       entering_second_next;
  logic       locked_next;

  logic       out_valid;
  echo_t      out_kind;
  logic [7:0] out_value;
  logic       out_rvalid;
  logic [7:0] out_rvalue;
  logic       out_locked;

  echo_t      kind_next;
  logic [7:0] value_next;
  logic       rvalid_next;
  logic [7:0] rvalue_next;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic       accept;
  logic       needs_alu;
  logic       put;
  logic [7:0] digit_op;
  logic [7:0] scaled;

  kfc_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign key_chan.ready = (state == S_IDLE);
  assign accept         = key_chan.valid && key_chan.ready;
  assign needs_alu      = !locked && key_chan.key_code != KEY_CLEAR &&
                          (key_chan.key_code == KEY_EQUALS ||
                           op_of(key_chan.key_code) != OP_NONE);
  assign put            = (state == S_PUT) && (!out_valid || result_chan.ready);

  assign alu_req.start = accept && needs_alu;
  assign alu_req.op    = pending_op;
  assign alu_req.a     = first_operand;
  assign alu_req.b     = second_operand;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = needs_alu ? S_CALC : S_PUT;
        end
      end
      S_CALC: begin
        if (alu_rsp.done) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (put) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Operand times ten plus the digit, wrapping at eight bits.
  assign digit_op = entering_first ? first_operand : second_operand;
  assign scaled   = {digit_op[4:0], 3'b000} + {digit_op[6:0], 1'b0} + key;

  always_comb begin
    first_operand_next   = first_operand;
    second_operand_next  = second_operand;
    pending_op_next      = pending_op;
    entering_first_next  = entering_first;
    entering_second_next = entering_second;
    locked_next          = locked;
    kind_next            = ECHO_NONE;
    value_next           = '0;
    rvalid_next          = 1'b0;
    rvalue_next          = '0;
    if (key == KEY_CLEAR) begin
      first_operand_next   = '0;
      second_operand_next  = '0;
      pending_op_next      = OP_NONE;
      entering_first_next  = 1'b1;
      entering_second_next = 1'b0;
      locked_next          = 1'b0;
      kind_next            = ECHO_CLEAR;
    end else if (locked) begin
      kind_next = ECHO_NONE;
    end else if (key < DIGIT_BASE) begin
      if (entering_first) begin
        first_operand_next = scaled;
        kind_next          = ECHO_DIGIT;
        value_next         = key;
      end else if (entering_second) begin
        second_operand_next = scaled;
        kind_next           = ECHO_DIGIT;
        value_next          = key;
      end
    end else begin
      kind_next  = ECHO_CHAR;
      value_next = key;
      if (key == KEY_EQUALS) begin
        rvalid_next          = 1'b1;
        rvalue_next          = alu_rsp.result;
        locked_next          = 1'b1;
        entering_first_next  = 1'b0;
        entering_second_next = 1'b0;
      end else if (op_of(key) != OP_NONE) begin
        first_operand_next   = alu_rsp.result;
        pending_op_next      = op_of(key);
        entering_first_next  = 1'b0;
        entering_second_next = 1'b1;
        second_operand_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      first_operand   <= '0;
      second_operand  <= '0;
      pending_op      <= OP_NONE;
      entering_first  <= 1'b1;
      entering_second <= 1'b0;
      locked          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        key <= key_chan.key_code;
      end
      if (put) begin
        first_operand   <= first_operand_next;
        second_operand  <= second_operand_next;
        pending_op      <= pending_op_next;
        entering_first  <= entering_first_next;
        entering_second <= entering_second_next;
        locked          <= locked_next;
        out_valid       <= 1'b1;
        out_kind        <= kind_next;
        out_value       <= value_next;
        out_rvalid      <= rvalid_next;
        out_rvalue      <= rvalue_next;
        out_locked      <= locked_next;
      end else if (out_valid && result_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result_chan.valid        = out_valid;
  assign result_chan.echo_kind    = out_kind;
  assign result_chan.echo_value   = out_value;
  assign result_chan.result_valid = out_rvalid;
  assign result_chan.result_value = out_rvalue;
  assign result_chan.is_locked    = out_locked;

  `ASSERT_NEXT(a_accept_leaves_idle, accept, state != S_IDLE,
    "accepted key did not leave the idle state")
  `ASSERT_SAME(a_done_only_in_calc, alu_rsp.done, state == S_CALC,
    "arithmetic unit finished outside the calculate state")
  `ASSERT_SAME(a_result_locks, out_valid && out_rvalid, out_locked,
    "result word without the lock flag")
  `ASSERT_NEXT(a_put_fills_output, put, out_valid,
    "finished word did not reach the output register")

endmodule
